FILE: rtl/fhc_pkg.sv
// ----------------------------------------------------------------------------
// fhc_pkg
// Shared types and constants of the frame header classifier.
// ----------------------------------------------------------------------------
package fhc_pkg;

  // Record geometry.
  localparam int REC_WORDS = 10;
  localparam int PAY_LIMIT = 37;

  // EtherTypes and IP protocols.
  localparam logic [15:0] ETH_ARP = 16'h0806;
  localparam logic [15:0] ETH_IP  = 16'h0800;
  localparam logic [7:0]  PR_ICMP = 8'h01;
  localparam logic [7:0]  PR_TCP  = 8'h06;
  localparam logic [7:0]  PR_UDP  = 8'h11;

  // Event type codes, written to record byte 0.
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_ARP  = 3'd1;
  localparam logic [2:0] KIND_TCP  = 3'd2;
  localparam logic [2:0] KIND_UDP  = 3'd3;
  localparam logic [2:0] KIND_ICMP = 3'd4;
  localparam logic [2:0] KIND_DNS  = 3'd5;
  localparam logic [2:0] KIND_HTTP = 3'd6;
  localparam logic [2:0] KIND_TLS  = 3'd7;

  // Configuration register indexes.
  localparam logic [2:0] REG_DNS_PORT      = 3'd0;
  localparam logic [2:0] REG_HTTP_PORT     = 3'd1;
  localparam logic [2:0] REG_HTTP_ALT_PORT = 3'd2;
  localparam logic [2:0] REG_TLS_PORT      = 3'd3;
  localparam logic [2:0] REG_TLS_ALT_PORT  = 3'd4;

  // HTTP method prefixes, first byte in the top bits.
  localparam logic [31:0] HTTP_GET  = 32'h47455420;
  localparam logic [31:0] HTTP_POST = 32'h504F5354;
  localparam logic [31:0] HTTP_HEAD = 32'h48454144;
  localparam logic [31:0] HTTP_PUT  = 32'h50555420;
  localparam logic [31:0] HTTP_DELE = 32'h44454C45;

  // TLS handshake prefix.
  localparam logic [7:0] TLS_HANDSHAKE = 8'h16;
  localparam logic [7:0] TLS_MAJOR     = 8'h03;
  localparam logic [7:0] TLS_MINOR_MAX = 8'h04;

  localparam logic [7:0] TCP_FLAG_MASK = 8'h1F;

  typedef struct packed {
    logic [15:0] dns;
    logic [15:0] http;
    logic [15:0] http_alt;
    logic [15:0] tls;
    logic [15:0] tls_alt;
  } port_cfg_t;

  // One record byte write from the parser.
  typedef struct packed {
    logic       en;
    logic [6:0] idx;
    logic [7:0] data;
  } wr_t;

  // Frame end event with its classification.
  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic [7:0] proto;
  } fin_t;

  // Record word read request.
  typedef struct packed {
    logic       en;
    logic [3:0] row;
  } rd_t;

  // Fixed ARP header bytes (hardware type, protocol, lengths).
  function automatic logic [7:0] arp_hdr_byte(input logic [2:0] i);
    logic [7:0] v;
    unique case (i)
      3'd0:    v = 8'h00;
      3'd1:    v = 8'h01;
      3'd2:    v = 8'h08;
      3'd3:    v = 8'h00;
      3'd4:    v = 8'h06;
      3'd5:    v = 8'h04;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/frame_header_classifier.sv
// ----------------------------------------------------------------------------
// frame_header_classifier
// Ethernet / ARP / IPv4 header classifier producing ten-word event records.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------
//  cfg      | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//  in       | in        | in_valid/in_stall  | frame_byte, frame_end
//  out      | out       | out_valid/out_stall| word_index, record_word, last_word
//
// One frame byte is taken every cycle unless in_stall is set. A record is read
// word by word from its RAM bank (read, then output register), a new read only
// once the last has left the RAM. Records are built in two banks; input stalls
// only while both hold records waiting for the output. Per-byte valid bits replace
// a clearing pass, so the block accepts bytes from the first cycle after reset.
// ----------------------------------------------------------------------------
module frame_header_classifier import fhc_pkg::*; #(
  parameter int MAX_FRAME     = 2048,
  parameter int PAYLOAD_BYTES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  frame_byte,
  input  logic        frame_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  word_index,
  output logic [63:0] record_word,
  output logic        last_word
);

  port_cfg_t   ports;
  wr_t         wr;
  fin_t        fin;
  rd_t         rd;
  logic        rel;
  logic        accept;
  logic        wb, rb;
  logic [1:0]  bank_full;
  logic [2:0]  bank_kind [2];
  logic [7:0]  bank_proto [2];
  logic [79:0] vld [2];
  logic [63:0] rdata;
  logic [7:0]  vmask;

  assign cfg_ready = 1'b1;
  assign in_stall  = bank_full[wb];
  assign accept    = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ports.dns      <= 16'd53;
      ports.http     <= 16'd80;
      ports.http_alt <= 16'd8080;
      ports.tls      <= 16'd443;
      ports.tls_alt  <= 16'd8443;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DNS_PORT:      ports.dns      <= cfg_data;
        REG_HTTP_PORT:     ports.http     <= cfg_data;
        REG_HTTP_ALT_PORT: ports.http_alt <= cfg_data;
        REG_TLS_PORT:      ports.tls      <= cfg_data;
        REG_TLS_ALT_PORT:  ports.tls_alt  <= cfg_data;
        default: ;
      endcase
    end
  end

  fhc_parser #(
    .MAX_FRAME     (MAX_FRAME),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .frame_byte (frame_byte),
    .frame_end  (frame_end),
    .ports      (ports),
    .wr         (wr),
    .fin        (fin)
  );

  // Record store: one byte lane per RAM, row address {bank, word}.
  for (genvar j = 0; j < 8; j++) begin : g_lane
    fhc_ram #(
      .WIDTH (8),
      .DEPTH (32)
    ) u_ram (
      .clk   (clk),
      .we    (wr.en && (wr.idx[2:0] == 3'(j))),
      .waddr ({wb, wr.idx[6:3]}),
      .wdata (wr.data),
      .re    (rd.en),
      .raddr ({rb, rd.row}),
      .rdata (rdata[j*8 +: 8])
    );
  end

  assign vmask = vld[rb][{rd.row, 3'b000} +: 8];

  // Bank ownership and per-byte valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      wb        <= 1'b0;
      rb        <= 1'b0;
      bank_full <= '0;
      vld[0]    <= '0;
      vld[1]    <= '0;
    end else begin
      if (wr.en) begin
        vld[wb][wr.idx] <= 1'b1;
      end
      if (fin.valid) begin
        if (fin.kind == KIND_NONE) begin
          vld[wb] <= '0;
        end else begin
          bank_full[wb] <= 1'b1;
          wb            <= !wb;
        end
      end
      if (rel) begin
        bank_full[rb] <= 1'b0;
        vld[rb]       <= '0;
        rb            <= !rb;
      end
    end
  end

  // Record type and protocol bytes kept per bank.
  always_ff @(posedge clk) begin
    if (fin.valid && (fin.kind != KIND_NONE)) begin
      bank_kind[wb]  <= fin.kind;
      bank_proto[wb] <= fin.proto;
    end
  end

  fhc_reader u_reader (
    .clk         (clk),
    .rst         (rst),
    .busy        (bank_full[rb]),
    .rdata       (rdata),
    .vmask       (vmask),
    .kind        (bank_kind[rb]),
    .proto       (bank_proto[rb]),
    .rd          (rd),
    .rel         (rel),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .word_index  (word_index),
    .record_word (record_word),
    .last_word   (last_word)
  );

  // A frame never ends into a bank that still holds a record.
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    fin.valid |-> !bank_full[wb])
    else $error("frame end into occupied bank");

  // Only a filled bank is released.
  a_rel_full: assert property (@(posedge clk) disable iff (rst)
    rel |-> bank_full[rb])
    else $error("release of empty bank");

  // Both banks full means the writer waits on the reader's bank.
  a_both_full: assert property (@(posedge clk) disable iff (rst)
    (bank_full == 2'b11) |-> (wb == rb))
    else $error("bank pointers out of step");

endmodule

FILE: rtl/fhc_ram.sv
// ----------------------------------------------------------------------------
// fhc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fhc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/fhc_parser.sv
// ----------------------------------------------------------------------------
// fhc_parser
// Byte-serial header parser: turns each frame byte into at most one record
// byte write and classifies the frame on its last byte.
// ----------------------------------------------------------------------------
module fhc_parser import fhc_pkg::*; #(
  parameter int MAX_FRAME     = 2048,
  parameter int PAYLOAD_BYTES = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  logic [7:0] frame_byte,
  input  logic      frame_end,
  input  port_cfg_t ports,
  output wr_t       wr,
  output fin_t      fin
);

  localparam int PW      = $clog2(MAX_FRAME + 1);
  localparam int LW      = (PW > 8) ? PW + 1 : 9;
  localparam int PAY_CAP = (PAYLOAD_BYTES > PAY_LIMIT) ? PAY_LIMIT : PAYLOAD_BYTES;
  localparam int CW      = $clog2(PAY_CAP + 1);

  logic [PW-1:0] pos, pos_n;
  logic [15:0]   ek, ek_n;
  logic [7:0]    proto, proto_n;
  logic [6:0]    l4, l4_n;
  logic [7:0]    ps, ps_n;
  logic          pk, pk_n;
  logic [CW-1:0] cnt, cnt_n;
  logic          ok, ok_n;
  logic [15:0]   sp, sp_n, dp, dp_n;
  logic [7:0]    q [6];
  logic [7:0]    q_n [6];

  logic [PW-1:0] p;
  logic [PW-1:0] off;
  logic [3:0]    doff;
  logic [LW-1:0] len;
  logic [2:0]    kind;
  logic          http_port_hit, tls_port_hit, http_pfx, tls_pfx;

  assign p   = pos;
  assign off = pos - PW'(l4);

  // Per-byte field extraction.
  always_comb begin
    pos_n   = pos;
    ek_n    = ek;
    proto_n = proto;
    l4_n    = l4;
    ps_n    = ps;
    pk_n    = pk;
    cnt_n   = cnt;
    ok_n    = ok;
    sp_n    = sp;
    dp_n    = dp;
    q_n     = q;
    wr      = '0;
    doff    = frame_byte[7:4];
    if (accept && (pos < PW'(MAX_FRAME))) begin
      pos_n   = pos + PW'(1);
      wr.data = frame_byte;
      if (p < PW'(6)) begin
        wr.en  = 1'b1;
        wr.idx = 7'(p) + 7'd7;
      end else if (p < PW'(12)) begin
        wr.en  = 1'b1;
        wr.idx = 7'(p) - 7'd5;
      end else if (p == PW'(12)) begin
        ek_n = {frame_byte, 8'h00};
      end else if (p == PW'(13)) begin
        ek_n = {ek[15:8], frame_byte};
        ok_n = 1'b1;
      end else if (ek == ETH_ARP) begin
        // ARP body: header checks, opcode and addresses.
        if (p <= PW'(19)) begin
          if (frame_byte != arp_hdr_byte(3'(p - PW'(14)))) begin
            ok_n = 1'b0;
          end
        end else if (p == PW'(20)) begin
          wr.en  = 1'b1;
          wr.idx = 7'd28;
        end else if (p == PW'(21)) begin
          wr.en  = 1'b1;
          wr.idx = 7'd27;
        end else if (p <= PW'(27)) begin
          wr.en  = 1'b1;
          wr.idx = 7'(p) + 7'd7;
        end else if (p <= PW'(31)) begin
          wr.en  = 1'b1;
          wr.idx = 7'(p) - 7'd15;
        end else if (p <= PW'(37)) begin
          wr.en  = 1'b1;
          wr.idx = 7'(p) + 7'd3;
        end else if (p <= PW'(41)) begin
          wr.en  = 1'b1;
          wr.idx = 7'(p) - 7'd21;
        end
      end else if (ek == ETH_IP) begin
        if (p == PW'(14)) begin
          if (frame_byte[3:0] < 4'd5) begin
            ok_n = 1'b0;
          end else begin
            l4_n = 7'd14 + {1'b0, frame_byte[3:0], 2'b00};
          end
        end else begin
          if (p == PW'(23)) begin
            proto_n = frame_byte;
          end else if ((p >= PW'(26)) && (p <= PW'(33))) begin
            wr.en  = 1'b1;
            wr.idx = 7'(p) - 7'd13;
          end
          // Transport header and payload.
          if (ok && (l4 != 7'd0) && (p >= PW'(l4))) begin
            if ((proto == PR_TCP) || (proto == PR_UDP)) begin
              if (off == PW'(0)) begin
                wr.en = 1'b1;
                wr.idx = 7'd22;
                sp_n[15:8] = frame_byte;
              end else if (off == PW'(1)) begin
                wr.en = 1'b1;
                wr.idx = 7'd21;
                sp_n[7:0] = frame_byte;
              end else if (off == PW'(2)) begin
                wr.en = 1'b1;
                wr.idx = 7'd24;
                dp_n[15:8] = frame_byte;
              end else if (off == PW'(3)) begin
                wr.en = 1'b1;
                wr.idx = 7'd23;
                dp_n[7:0] = frame_byte;
              end
              if ((proto == PR_UDP) && (off == PW'(0))) begin
                ps_n = {1'b0, l4} + 8'd8;
                pk_n = 1'b1;
              end
              if ((proto == PR_TCP) && (off == PW'(12))) begin
                if (doff < 4'd5) begin
                  ok_n = 1'b0;
                end else begin
                  ps_n = {1'b0, l4} + {2'b00, doff, 2'b00};
                  pk_n = 1'b1;
                end
              end
              if ((proto == PR_TCP) && (off == PW'(13))) begin
                wr.en   = 1'b1;
                wr.idx  = 7'd26;
                wr.data = frame_byte & TCP_FLAG_MASK;
              end
              if (pk && (LW'(p) >= LW'(ps)) && (cnt < CW'(PAY_CAP))) begin
                wr.en  = 1'b1;
                wr.idx = 7'(cnt) + 7'd43;
                cnt_n  = cnt + CW'(1);
                if (cnt < CW'(6)) begin
                  q_n[cnt[2:0]] = frame_byte;
                end
              end
            end else if (proto == PR_ICMP) begin
              if (off == PW'(0)) begin
                wr.en  = 1'b1;
                wr.idx = 7'd41;
              end else if (off == PW'(1)) begin
                wr.en  = 1'b1;
                wr.idx = 7'd42;
              end
            end
          end
        end
      end
    end
  end

  // Prefix and port tests on the updated state.
  assign http_port_hit = (sp_n == ports.http) || (sp_n == ports.http_alt) ||
                         (dp_n == ports.http) || (dp_n == ports.http_alt);
  assign tls_port_hit  = (sp_n == ports.tls) || (sp_n == ports.tls_alt) ||
                         (dp_n == ports.tls) || (dp_n == ports.tls_alt);
  assign http_pfx = ({q_n[0], q_n[1], q_n[2], q_n[3]} == HTTP_GET)  ||
                    ({q_n[0], q_n[1], q_n[2], q_n[3]} == HTTP_POST) ||
                    ({q_n[0], q_n[1], q_n[2], q_n[3]} == HTTP_HEAD) ||
                    ({q_n[0], q_n[1], q_n[2], q_n[3]} == HTTP_PUT)  ||
                    ({q_n[0], q_n[1], q_n[2], q_n[3]} == HTTP_DELE);
  assign tls_pfx  = (q_n[0] == TLS_HANDSHAKE) && (q_n[1] == TLS_MAJOR) &&
                    (q_n[2] <= TLS_MINOR_MAX);
  assign len = LW'(pos_n);

  // Frame classification on the last byte.
  always_comb begin
    kind = KIND_NONE;
    if (ok_n && (len >= LW'(14))) begin
      if (ek_n == ETH_ARP) begin
        if (len >= LW'(42)) begin
          kind = KIND_ARP;
        end
      end else if ((ek_n == ETH_IP) && (len >= LW'(34)) && (l4_n != 7'd0)) begin
        if (proto_n == PR_ICMP) begin
          if (len >= LW'(l4_n) + LW'(8)) begin
            kind = KIND_ICMP;
          end
        end else if (proto_n == PR_UDP) begin
          if (len >= LW'(l4_n) + LW'(8)) begin
            kind = ((sp_n == ports.dns) || (dp_n == ports.dns)) ? KIND_DNS : KIND_UDP;
          end
        end else if (proto_n == PR_TCP) begin
          if ((len >= LW'(l4_n) + LW'(20)) && pk_n) begin
            kind = KIND_TCP;
            if ((cnt_n >= CW'(4)) && http_port_hit && http_pfx) begin
              kind = KIND_HTTP;
            end
            if ((cnt_n >= CW'(6)) && tls_port_hit && tls_pfx) begin
              kind = KIND_TLS;
            end
          end
        end
      end
    end
  end

  assign fin.valid = accept && frame_end;
  assign fin.kind  = kind;
  assign fin.proto = (kind == KIND_ARP) ? 8'h00 : proto_n;

  // Per-frame state, cleared at every frame end.
  always_ff @(posedge clk) begin
    if (rst || fin.valid) begin
      pos   <= '0;
      ek    <= '0;
      proto <= '0;
      l4    <= '0;
      ps    <= '0;
      pk    <= 1'b0;
      cnt   <= '0;
      ok    <= 1'b0;
      sp    <= '0;
      dp    <= '0;
    end else if (accept) begin
      pos   <= pos_n;
      ek    <= ek_n;
      proto <= proto_n;
      l4    <= l4_n;
      ps    <= ps_n;
      pk    <= pk_n;
      cnt   <= cnt_n;
      ok    <= ok_n;
      sp    <= sp_n;
      dp    <= dp_n;
    end
  end

  // Shadow copy of the first payload bytes for the prefix tests.
  always_ff @(posedge clk) begin
    if (accept) begin
      q <= q_n;
    end
  end

endmodule

FILE: rtl/fhc_reader.sv
// ----------------------------------------------------------------------------
// fhc_reader
// Drains a finished record bank, one 64-bit word per read, into the output
// register, filling in the event type and protocol bytes.
// ----------------------------------------------------------------------------
module fhc_reader import fhc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        busy,
  input  logic [63:0] rdata,
  input  logic [7:0]  vmask,
  input  logic [2:0]  kind,
  input  logic [7:0]  proto,
  output rd_t         rd,
  output logic        rel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  word_index,
  output logic [63:0] record_word,
  output logic        last_word
);

  logic [3:0]  cnt;
  logic        inflight;
  logic [3:0]  p_idx;
  logic [7:0]  p_vm;
  logic [2:0]  p_kind;
  logic [7:0]  p_proto;
  logic [63:0] word;

  // Issue a read when the output register is free by the next edge.
  assign rd.en  = busy && !inflight && (!out_valid || !out_stall);
  assign rd.row = cnt;
  assign rel    = rd.en && (cnt == 4'(REC_WORDS - 1));

  // Word assembly: unwritten bytes read as zero.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      word[j*8 +: 8] = p_vm[j] ? rdata[j*8 +: 8] : 8'h00;
    end
    if (p_idx == 4'd0) begin
      word[7:0] = {5'b00000, p_kind};
    end
    if (p_idx == 4'd3) begin
      word[15:8] = p_proto;
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      inflight  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      inflight <= rd.en;
      if (rd.en) begin
        cnt <= rel ? 4'd0 : cnt + 4'd1;
      end
      if (inflight) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload pipeline.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      p_idx   <= cnt;
      p_vm    <= vmask;
      p_kind  <= kind;
      p_proto <= proto;
    end
    if (inflight) begin
      word_index  <= p_idx;
      record_word <= word;
      last_word   <= (p_idx == 4'(REC_WORDS - 1));
    end
  end

endmodule
